FILE: hdl/vat_pkg.sv
`timescale 1ns / 1ps
package vat_pkg;

  // Number format and derived sizes.
  localparam int FRAC_BITS   = 16;
  localparam int WORD_BITS   = 32;
  localparam int LEN_BITS    = 31;
  localparam int DIV_STEPS   = LEN_BITS + FRAC_BITS;
  localparam int DIV_LAT     = DIV_STEPS + 1;
  localparam int PROD_BITS   = 2 * WORD_BITS - 1;
  localparam int MAG_BITS    = PROD_BITS - FRAC_BITS;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Alignment codes.
  localparam logic [3:0] ALIGN_UNKNOWN   = 4'd0;
  localparam logic [3:0] ALIGN_NONE      = 4'd1;
  localparam logic [3:0] ALIGN_XMIN_YMIN = 4'd2;
  localparam logic [3:0] ALIGN_XMID_YMIN = 4'd3;
  localparam logic [3:0] ALIGN_XMAX_YMIN = 4'd4;
  localparam logic [3:0] ALIGN_XMIN_YMID = 4'd5;
  localparam logic [3:0] ALIGN_XMID_YMID = 4'd6;
  localparam logic [3:0] ALIGN_XMAX_YMID = 4'd7;
  localparam logic [3:0] ALIGN_XMIN_YMAX = 4'd8;
  localparam logic [3:0] ALIGN_XMID_YMAX = 4'd9;
  localparam logic [3:0] ALIGN_XMAX_YMAX = 4'd10;

  // Fit mode code; every other code behaves as meet.
  localparam logic [1:0] FIT_SLICE = 2'd2;

  typedef enum logic [1:0] {
    PLACE_MIN,
    PLACE_MID,
    PLACE_MAX
  } place_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]         viewport_width;
    logic [LEN_BITS-1:0]         viewport_height;
    logic signed [WORD_BITS-1:0] box_x;
    logic signed [WORD_BITS-1:0] box_y;
    logic [LEN_BITS-1:0]         box_width;
    logic [LEN_BITS-1:0]         box_height;
    logic [3:0]                  align_mode;
    logic [1:0]                  fit_mode;
  } vat_req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] scale_x;
    logic signed [WORD_BITS-1:0] scale_y;
    logic signed [WORD_BITS-1:0] shift_x;
    logic signed [WORD_BITS-1:0] shift_y;
    logic                        saturated;
  } vat_rsp_t;

  // Classified work item handed from the front end to the back end.
  typedef struct packed {
    logic [WORD_BITS-1:0]        scale_x;
    logic [WORD_BITS-1:0]        scale_y;
    logic signed [WORD_BITS-1:0] box_x;
    logic signed [WORD_BITS-1:0] box_y;
    logic [LEN_BITS-1:0]         view_len;
    logic [LEN_BITS-1:0]         box_len;
    logic                        adjust;
    logic                        adj_y;
    place_t                      place;
    logic                        sat;
  } vat_job_t;

  typedef struct packed {
    logic                        sat;
    logic signed [WORD_BITS-1:0] value;
  } sat_word_t;

  // Placement of the slack on one axis for a given alignment.
  function automatic place_t align_place(input logic [3:0] align, input logic vertical);
    place_t col;
    place_t row;
    col = PLACE_MID;
    row = PLACE_MID;
    unique case (align)
      ALIGN_XMIN_YMIN: begin col = PLACE_MIN; row = PLACE_MIN; end
      ALIGN_XMID_YMIN: begin col = PLACE_MID; row = PLACE_MIN; end
      ALIGN_XMAX_YMIN: begin col = PLACE_MAX; row = PLACE_MIN; end
      ALIGN_XMIN_YMID: begin col = PLACE_MIN; row = PLACE_MID; end
      ALIGN_XMID_YMID: begin col = PLACE_MID; row = PLACE_MID; end
      ALIGN_XMAX_YMID: begin col = PLACE_MAX; row = PLACE_MID; end
      ALIGN_XMIN_YMAX: begin col = PLACE_MIN; row = PLACE_MAX; end
      ALIGN_XMID_YMAX: begin col = PLACE_MID; row = PLACE_MAX; end
      ALIGN_XMAX_YMAX: begin col = PLACE_MAX; row = PLACE_MAX; end
      default:         begin col = PLACE_MID; row = PLACE_MID; end
    endcase
    return vertical ? row : col;
  endfunction

  // Rounds a product magnitude to the word, applies the sign and saturates.
  function automatic sat_word_t mul_round(input logic [PROD_BITS-1:0] prod, input logic neg);
    logic [PROD_BITS-1:0] biased;
    logic [MAG_BITS-1:0]  mag;
    logic [MAG_BITS-1:0]  lim;
    sat_word_t            r;
    biased = prod + (PROD_BITS'(1) << (FRAC_BITS - 1));
    mag    = biased[PROD_BITS-1:FRAC_BITS];
    lim    = MAG_BITS'(WORD_MAX) + MAG_BITS'(neg);
    r.sat  = mag > lim;
    if (r.sat) begin
      r.value = neg ? WORD_MIN : WORD_MAX;
    end else begin
      r.value = neg ? (~mag[WORD_BITS-1:0] + 1'b1) : mag[WORD_BITS-1:0];
    end
    return r;
  endfunction

  // Clamps a value two bits wider than the word into the word range.
  function automatic sat_word_t clamp_word(input logic signed [WORD_BITS+1:0] v);
    sat_word_t r;
    r.sat = !((v[WORD_BITS+1:WORD_BITS-1] == 3'b000) ||
              (v[WORD_BITS+1:WORD_BITS-1] == 3'b111));
    if (r.sat) begin
      r.value = v[WORD_BITS+1] ? WORD_MIN : WORD_MAX;
    end else begin
      r.value = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  // Halves a value, rounding ties away from zero.
  function automatic logic [WORD_BITS-1:0] halve_word(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS:0] m;
    logic [WORD_BITS:0] h;
    logic [WORD_BITS:0] r;
    m = v[WORD_BITS-1] ? (~{1'b1, v} + 1'b1) : {1'b0, v};
    h = (m + 1'b1) >> 1;
    r = v[WORD_BITS-1] ? (~h + 1'b1) : h;
    return r[WORD_BITS-1:0];
  endfunction

  function automatic logic [WORD_BITS-1:0] place_offset(input logic [WORD_BITS-1:0] slack,
                                                        input place_t p);
    logic [WORD_BITS-1:0] r;
    unique case (p)
      PLACE_MIN: r = '0;
      PLACE_MID: r = halve_word(slack);
      PLACE_MAX: r = slack;
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/vat_divider.sv
`timescale 1ns / 1ps
module vat_divider (
  input  logic                           clk,
  input  logic                           en,
  input  logic [vat_pkg::LEN_BITS-1:0]   num,
  input  logic [vat_pkg::LEN_BITS-1:0]   den,
  output logic [vat_pkg::WORD_BITS-1:0]  ratio,
  output logic                           sat
);
  import vat_pkg::*;

  logic [LEN_BITS-1:0]  num_s [DIV_STEPS+1];
  logic [LEN_BITS-1:0]  den_s [DIV_STEPS+1];
  logic [LEN_BITS-1:0]  rem_s [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_s [DIV_STEPS+1];

  assign num_s[0] = num;
  assign den_s[0] = den;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;

  // One restoring step per stage; the dividend is the numerator followed by
  // the fraction zeros, fed in one bit per stage from the top.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [LEN_BITS:0] trial;
    logic [LEN_BITS:0] diff;
    logic              take;

    always_comb begin
      trial = {rem_s[s], num_s[s][LEN_BITS-1]};
      diff  = trial - {1'b0, den_s[s]};
      take  = trial >= {1'b0, den_s[s]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_s[s+1] <= num_s[s] << 1;
        den_s[s+1] <= den_s[s];
        rem_s[s+1] <= take ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
        quo_s[s+1] <= {quo_s[s][DIV_STEPS-2:0], take};
      end
    end
  end

  // Final rounding on the remainder, then saturation to the word maximum.
  logic              round_up;
  logic [DIV_STEPS:0] full;
  logic              over;

  always_comb begin
    round_up = {rem_s[DIV_STEPS], 1'b0} >= {1'b0, den_s[DIV_STEPS]};
    full     = {1'b0, quo_s[DIV_STEPS]} + (DIV_STEPS+1)'(round_up);
    over     = full > (DIV_STEPS+1)'(WORD_MAX);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ratio <= over ? WORD_MAX : full[WORD_BITS-1:0];
      sat   <= over;
    end
  end

endmodule

FILE: hdl/vat_front.sv
`timescale 1ns / 1ps
module vat_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  vat_pkg::vat_req_t req,
  output logic              push,
  output vat_pkg::vat_job_t job,
  input  logic              full
);
  import vat_pkg::*;

  logic                 en;
  logic [DIV_LAT-1:0]   vld;
  vat_req_t             line [DIV_LAT];
  logic [WORD_BITS-1:0] ratio_x;
  logic [WORD_BITS-1:0] ratio_y;
  logic                 sat_x;
  logic                 sat_y;

  // The whole front pipeline moves whenever the queue has room.
  assign en        = !full;
  assign req_stall = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_LAT-2:0], req_valid};
    end
  end

  // Request fields travel alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= req;
      for (int i = 1; i < DIV_LAT; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  vat_divider u_div_x (
    .clk   (clk),
    .en    (en),
    .num   (req.viewport_width),
    .den   (req.box_width),
    .ratio (ratio_x),
    .sat   (sat_x)
  );

  vat_divider u_div_y (
    .clk   (clk),
    .en    (en),
    .num   (req.viewport_height),
    .den   (req.box_height),
    .ratio (ratio_y),
    .sat   (sat_y)
  );

  // Classification: pick the common scale and the axis that takes the slack.
  vat_req_t   src;
  logic [3:0] align;
  logic       slice;
  logic       adjust;
  logic       adj_y;

  always_comb begin
    src   = line[DIV_LAT-1];
    align = src.align_mode;
    if (align == ALIGN_UNKNOWN || align > ALIGN_XMAX_YMAX) begin
      align = ALIGN_XMID_YMID;
    end
    slice  = src.fit_mode == FIT_SLICE;
    adjust = (align != ALIGN_NONE) && (ratio_x != ratio_y);
    adj_y  = slice ? (ratio_y < ratio_x) : (ratio_x < ratio_y);

    job.scale_x  = (adjust && !adj_y) ? ratio_y : ratio_x;
    job.scale_y  = (adjust && adj_y) ? ratio_x : ratio_y;
    job.box_x    = src.box_x;
    job.box_y    = src.box_y;
    job.view_len = adj_y ? src.viewport_height : src.viewport_width;
    job.box_len  = adj_y ? src.box_height : src.box_width;
    job.adjust   = adjust;
    job.adj_y    = adj_y;
    job.place    = align_place(align, adj_y);
    job.sat      = sat_x | sat_y;
  end

  assign push = vld[DIV_LAT-1] && en;

endmodule

FILE: hdl/vat_queue.sv
`timescale 1ns / 1ps
module vat_queue #(
  parameter int DEPTH = vat_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vat_pkg::vat_job_t din,
  input  logic              pop,
  output vat_pkg::vat_job_t dout,
  output logic              full,
  output logic              empty
);
  import vat_pkg::*;

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  vat_job_t            mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full  = count == CNT_BITS'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("queue count out of range");
  a_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == CNT_BITS'(DEPTH - 1)) |=> full)
    else $error("queue did not report full");

endmodule

FILE: hdl/vat_back.sv
`timescale 1ns / 1ps
module vat_back (
  input  logic              clk,
  input  logic              rst,
  output logic              pop,
  input  vat_pkg::vat_job_t job,
  input  logic              empty,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output vat_pkg::vat_rsp_t rsp
);
  import vat_pkg::*;

  logic en;

  assign en  = !rsp_valid || !rsp_stall;
  assign pop = !empty && en;

  // Stage 1: the three products.
  logic [WORD_BITS-1:0]   mag_x;
  logic [WORD_BITS-1:0]   mag_y;
  logic [2*WORD_BITS-1:0] prod_s;
  logic [2*WORD_BITS-1:0] prod_x;
  logic [2*WORD_BITS-1:0] prod_y;

  always_comb begin
    mag_x  = job.box_x[WORD_BITS-1] ? (~job.box_x + 1'b1) : job.box_x;
    mag_y  = job.box_y[WORD_BITS-1] ? (~job.box_y + 1'b1) : job.box_y;
    prod_s = job.scale_x * {1'b0, job.box_len};
    prod_x = job.scale_x * mag_x;
    prod_y = job.scale_y * mag_y;
  end

  logic                 v1;
  vat_job_t             j1;
  logic [PROD_BITS-1:0] p_s;
  logic [PROD_BITS-1:0] p_x;
  logic [PROD_BITS-1:0] p_y;

  always_ff @(posedge clk) begin
    if (en) begin
      j1  <= job;
      p_s <= prod_s[PROD_BITS-1:0];
      p_x <= prod_x[PROD_BITS-1:0];
      p_y <= prod_y[PROD_BITS-1:0];
    end
  end

  // Stage 2: round and saturate the products.
  sat_word_t r_s;
  sat_word_t r_x;
  sat_word_t r_y;

  always_comb begin
    r_s = mul_round(p_s, 1'b0);
    r_x = mul_round(p_x, j1.box_x[WORD_BITS-1]);
    r_y = mul_round(p_y, j1.box_y[WORD_BITS-1]);
  end

  logic                        v2;
  vat_job_t                    j2;
  logic signed [WORD_BITS-1:0] m_s;
  logic signed [WORD_BITS-1:0] m_x;
  logic signed [WORD_BITS-1:0] m_y;
  logic                        sat2;

  always_ff @(posedge clk) begin
    if (en) begin
      j2   <= j1;
      m_s  <= r_s.value;
      m_x  <= r_x.value;
      m_y  <= r_y.value;
      sat2 <= j1.sat | (j1.adjust & r_s.sat) | r_x.sat | r_y.sat;
    end
  end

  // Stage 3: slack on the adjusted axis and its placement.
  logic signed [WORD_BITS+1:0] slack_wide;
  sat_word_t                   slack;
  logic [WORD_BITS-1:0]        off;

  always_comb begin
    slack_wide = $signed({3'b000, j2.view_len}) - {{2{m_s[WORD_BITS-1]}}, m_s};
    slack      = clamp_word(slack_wide);
    off        = place_offset(slack.value, j2.place);
  end

  logic                        v3;
  vat_job_t                    j3;
  logic signed [WORD_BITS-1:0] e0;
  logic signed [WORD_BITS-1:0] f0;
  logic signed [WORD_BITS-1:0] m_x3;
  logic signed [WORD_BITS-1:0] m_y3;
  logic                        sat3;

  always_ff @(posedge clk) begin
    if (en) begin
      j3   <= j2;
      e0   <= (j2.adjust && !j2.adj_y) ? off : '0;
      f0   <= (j2.adjust && j2.adj_y) ? off : '0;
      m_x3 <= m_x;
      m_y3 <= m_y;
      sat3 <= sat2 | (j2.adjust & slack.sat);
    end
  end

  // Stage 4: subtract the origin terms into the output register.
  sat_word_t sh_x;
  sat_word_t sh_y;

  always_comb begin
    sh_x = clamp_word({{2{e0[WORD_BITS-1]}}, e0} - {{2{m_x3[WORD_BITS-1]}}, m_x3});
    sh_y = clamp_word({{2{f0[WORD_BITS-1]}}, f0} - {{2{m_y3[WORD_BITS-1]}}, m_y3});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.scale_x   <= j3.scale_x;
      rsp.scale_y   <= j3.scale_y;
      rsp.shift_x   <= sh_x.value;
      rsp.shift_y   <= sh_y.value;
      rsp.saturated <= sat3 | sh_x.sat | sh_y.sat;
    end
  end

  // Valid bits of the back pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      v1        <= pop;
      v2        <= v1;
      v3        <= v2;
      rsp_valid <= v3;
    end
  end

endmodule

FILE: hdl/viewbox_aspect_transform_unit.sv
`timescale 1ns / 1ps
// Fits a viewbox into a viewport and returns the scale and translation of the
// fitting transform in signed Q16.16, with every clamp reported on saturated.
// One transaction is taken per clock and one result leaves per clock while no
// stall holds them. A transaction passes the two pipelined dividers of the front
// end (47 quotient-bit stages plus a rounding stage), is written into the queue,
// then runs through the multiply-and-finish pipeline of the back end: products,
// rounding, slack placement and the output register. A small queue between the
// two ends absorbs output stalls for a few transactions; once it fills, the input
// is stalled until the output moves again.
module viewbox_aspect_transform_unit #(
  parameter int QUEUE_DEPTH = vat_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  vat_pkg::vat_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output vat_pkg::vat_rsp_t rsp
);
  import vat_pkg::*;

  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  vat_job_t job_in;
  vat_job_t job_out;

  vat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .job       (job_in),
    .full      (full)
  );

  vat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .dout  (job_out),
    .full  (full),
    .empty (empty)
  );

  vat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .job       (job_out),
    .empty     (empty),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: tb/viewbox_aspect_transform_checker.sv
`timescale 1ns / 1ps
module viewbox_aspect_transform_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  vat_pkg::vat_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  vat_pkg::vat_rsp_t rsp,
  output int                fail_count,
  output int                pending_count
);
  import vat_pkg::*;

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;

  vat_rsp_t expected_fits[$];
  bit       clip;

  assign pending_count = expected_fits.size();

  function automatic longint clip_word(input longint v);
    if (v > LMAX) begin
      clip = 1'b1;
      return LMAX;
    end
    if (v < LMIN) begin
      clip = 1'b1;
      return LMIN;
    end
    return v;
  endfunction

  // Rounded quotient of two nonnegative lengths in fixed point.
  function automatic longint fit_ratio(input longint num, input longint den);
    longint q;
    longint rem;
    longint frac;
    longint res;
    if (den == 0) begin
      clip = 1'b1;
      return LMAX;
    end
    q = num / den;
    rem = num % den;
    frac = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem -= den;
        frac |= 1;
      end
    end
    if ((rem << 1) >= den) frac += 1;
    if (q > (LMAX >> FRAC_BITS)) begin
      clip = 1'b1;
      return LMAX;
    end
    res = (q << FRAC_BITS) + frac;
    if (res > LMAX) begin
      clip = 1'b1;
      return LMAX;
    end
    return res;
  endfunction

  // Fixed-point product with rounding and saturation; magnitudes fit 128 bits.
  function automatic longint fix_mul(input longint x, input longint y);
    logic         neg;
    logic [127:0] p;
    logic [127:0] m;
    logic [127:0] lim;
    neg = (x < 0) != (y < 0);
    p = 128'(x < 0 ? -x : x) * 128'(y < 0 ? -y : y);
    m = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? 128'(LMAX) + 1 : 128'(LMAX);
    if (m > lim) begin
      clip = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint slack_share(input longint s, input int pos);
    if (pos == 1) return (s >= 0) ? ((s + 1) >>> 1) : -((-s + 1) >>> 1);
    if (pos == 2) return s;
    return 0;
  endfunction

  function automatic vat_rsp_t fit_transform(input vat_req_t r);
    longint   vw, vh, bx, by, bw, bh, sx, sy, tx, ty;
    int       al;
    bit       slc;
    vat_rsp_t o;
    clip = 1'b0;
    vw = r.viewport_width;
    vh = r.viewport_height;
    bx = longint'(r.box_x);
    by = longint'(r.box_y);
    bw = r.box_width;
    bh = r.box_height;
    al = r.align_mode;
    slc = (r.fit_mode == FIT_SLICE);
    tx = 0;
    ty = 0;
    if (al == ALIGN_UNKNOWN || al > ALIGN_XMAX_YMAX) al = ALIGN_XMID_YMID;
    sx = fit_ratio(vw, bw);
    sy = fit_ratio(vh, bh);
    if (al != ALIGN_NONE && sx != sy) begin
      if ((!slc && sx < sy) || (slc && sy < sx)) begin
        sy = sx;
        ty = slack_share(clip_word(vh - fix_mul(sx, bh)), (al - 2) / 3);
      end else begin
        sx = sy;
        tx = slack_share(clip_word(vw - fix_mul(sy, bw)), (al - 2) % 3);
      end
    end
    tx = clip_word(tx - fix_mul(sx, bx));
    ty = clip_word(ty - fix_mul(sy, by));
    o.scale_x = sx[31:0];
    o.scale_y = sy[31:0];
    o.shift_x = tx[31:0];
    o.shift_y = ty[31:0];
    o.saturated = clip;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    vat_rsp_t w;
    if (!rst) begin
      if (req_valid && !req_stall) expected_fits.push_back(fit_transform(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_fits.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          w = expected_fits.pop_front();
          if (rsp.scale_x !== w.scale_x) report_mismatch("scale_x", rsp.scale_x, w.scale_x);
          if (rsp.scale_y !== w.scale_y) report_mismatch("scale_y", rsp.scale_y, w.scale_y);
          if (rsp.shift_x !== w.shift_x) report_mismatch("shift_x", rsp.shift_x, w.shift_x);
          if (rsp.shift_y !== w.shift_y) report_mismatch("shift_y", rsp.shift_y, w.shift_y);
          if (rsp.saturated !== w.saturated)
            report_mismatch("saturated", rsp.saturated, w.saturated);
        end
      end
    end
  end
endmodule

FILE: tb/viewbox_aspect_transform_unit_tb.sv
`timescale 1ns / 1ps
module viewbox_aspect_transform_unit_tb;
  import vat_pkg::*;

  localparam int LATENCY = 60;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  vat_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  vat_rsp_t rsp;
  int       fail_count;
  int       pending_count;
  bit       hold_rsp = 1'b0;
  bit       calm = 1'b0;

  always #6 clk = ~clk;

  viewbox_aspect_transform_unit u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  viewbox_aspect_transform_checker u_checker (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  function automatic logic [30:0] rand_len();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 3));
      1: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
      2: return 31'($urandom_range(1, 16) << 16);
      3: return 31'($urandom_range(0, 32'h00FF_FFFF));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] rand_box_len();
    logic [30:0] v;
    v = rand_len();
    return (v == 0) ? 31'd1 : v;
  endfunction

  function automatic logic [31:0] rand_origin();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  // Send one request transaction and wait for its acceptance.
  task automatic send_request(input vat_req_t r);
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  // Receiver stall pattern: random bursts, long holds on request.
  initial begin
    while (1) begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (200) @(posedge clk);
        rsp_stall <= 1'b0;
        hold_rsp = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    vat_req_t r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every alignment and fit code, plus extreme and equal sizes.
    for (int a = 0; a < 16; a++) begin
      r.viewport_width = 31'(100 << 16);
      r.viewport_height = 31'(50 << 16);
      r.box_x = 32'sh0001_8000;
      r.box_y = -32'sh0002_4000;
      r.box_width = 31'(40 << 16);
      r.box_height = 31'(30 << 16);
      r.align_mode = 4'(a);
      r.fit_mode = 2'(a % 4);
      send_request(r);
    end
    r = '0;
    r.box_width = 31'd1;
    r.box_height = 31'd1;
    r.align_mode = ALIGN_XMID_YMID;
    send_request(r);
    r.viewport_width = '1;
    r.viewport_height = '1;
    r.box_x = 32'sh7FFF_FFFF;
    r.box_y = 32'sh8000_0000;
    r.fit_mode = FIT_SLICE;
    send_request(r);
    r.box_width = '1;
    r.box_height = '1;
    r.align_mode = ALIGN_XMAX_YMAX;
    send_request(r);
    r.viewport_width = 31'(8 << 16);
    r.viewport_height = 31'(8 << 16);
    r.box_width = 31'(2 << 16);
    r.box_height = 31'(2 << 16);
    r.box_x = -32'sh0001_0000;
    r.box_y = 32'sh0001_0000;
    send_request(r);
    drain();

    // Random phase; one long output hold and one full drain midway.
    for (int i = 0; i < 1600; i++) begin
      r.viewport_width = rand_len();
      r.viewport_height = rand_len();
      r.box_x = rand_origin();
      r.box_y = rand_origin();
      r.box_width = rand_box_len();
      r.box_height = rand_box_len();
      r.align_mode = 4'($urandom_range(0, 15));
      r.fit_mode = 2'($urandom_range(0, 3));
      if (i == 300) hold_rsp = 1'b1;
      if (i == 800) drain();
      if (i == 1300) calm = 1'b1;
      send_request(r);
      maybe_gap();
    end
    drain();
    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/vat_pkg.sv
hdl/vat_divider.sv
hdl/vat_front.sv
hdl/vat_queue.sv
hdl/vat_back.sv
hdl/viewbox_aspect_transform_unit.sv
tb/viewbox_aspect_transform_checker.sv
tb/viewbox_aspect_transform_unit_tb.sv
